// ----- design/jls_pkg.sv -----
// Package for the Jacobi linear solver core: operation codes, widths, state encoding.
// No dependencies.
package jls_pkg;
  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_SOLVE  = 2'd2;
  localparam logic [1:0] OP_RSVD   = 2'd3;
  localparam logic       REG_SIZE  = 1'b0;
  localparam logic       REG_TOL   = 1'b1;
  localparam logic signed [31:0] Q_ONE = 32'sd65536;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_INIT  = 8'b0000_0010,
    ST_MAC   = 8'b0000_0100,
    ST_DIAG  = 8'b0000_1000,
    ST_DIV   = 8'b0001_0000,
    ST_CHECK = 8'b0010_0000,
    ST_COPY  = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic        start;
    logic signed [47:0] num;
    logic signed [31:0] den;
  } div_req_t;
endpackage

// ----- design/jls_divider.sv -----
// Restoring divider: signed Q16.16 quotient (num*65536)/den, truncated, saturated.
// Depends on jls_pkg.
module jls_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  jls_pkg::div_req_t   req_i,
  output logic                done_o,
  output logic signed [31:0]  quot_o
);
  logic [63:0] dvd_q, dvd_d;
  logic [31:0] dvs_q, dvs_d;
  logic [64:0] rem_q, rem_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [64:0] trial;
  logic [63:0] mag;
  logic [63:0] num_abs;
  logic signed [63:0] num_ext;

  assign num_ext = {req_i.num, 16'd0};
  assign num_abs = num_ext[63] ? 64'(-num_ext) : num_ext;
  assign trial   = {rem_q[63:0], dvd_q[63]} - {33'd0, dvs_q};
  assign mag     = dvd_q;

  always_comb begin
    dvd_d = dvd_q; dvs_d = dvs_q; rem_d = rem_q; cnt_d = cnt_q;
    neg_d = neg_q; busy_d = busy_q; done_d = 1'b0;
    if (req_i.start) begin
      dvd_d  = num_abs;
      dvs_d  = req_i.den[31] ? 32'(-req_i.den) : req_i.den;
      neg_d  = req_i.num[47] ^ req_i.den[31];
      rem_d  = '0;
      cnt_d  = 7'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial;
        dvd_d = {dvd_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[63:0], dvd_q[63]};
        dvd_d = {dvd_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  always_comb begin
    if (neg_q) quot_o = (mag > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-mag);
    else       quot_o = (mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : mag[31:0];
  end
  assign done_o = done_q;
endmodule

// ----- design/jacobi_linear_solver_core.sv -----
// Top level of the Jacobi linear solver core: memories, sequencer, result port.
// Depends on jls_pkg and jls_divider.
//
//  channel | handshake                   | payload
//  cmd     | start / busy                | operation_i row_i col_i value_i
//  cfg     | cfg_valid_i / cfg_ready_o   | cfg_index_i cfg_data_i
//  result  | result_valid_o (strobe)     | index_o solution_o iteration_count_o
//          |                             | converged_o divide_fault_o last_o
//
// Each load writes one memory word. A solve first fills the estimate, then per
// pass does matrix reads and a divide for each unknown (no divide when the
// diagonal is zero), then the change check and the copy; at most n passes, the
// final copy replaced by emitting the n results. The matrix memory port and the
// one-bit-a-cycle divider set the solve time. Reset clears control only; the
// result strobe cannot be held off.
module jacobi_linear_solver_core #(
  parameter int MAX_SIZE = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [5:0]  row_i,
  input  logic [5:0]  col_i,
  input  logic signed [31:0] value_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [30:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [5:0]  index_o,
  output logic signed [31:0] solution_o,
  output logic [6:0]  iteration_count_o,
  output logic        converged_o,
  output logic        divide_fault_o,
  output logic        last_o
);
  localparam int AW = (MAX_SIZE > 64) ? 6 : $clog2(MAX_SIZE);
  localparam int LIM = (MAX_SIZE > 64) ? 64 : MAX_SIZE;

  logic signed [31:0] mem_a [2**(2*AW)];
  logic signed [31:0] mem_b [MAX_SIZE];
  logic signed [31:0] mem_x [MAX_SIZE];
  logic signed [31:0] mem_y [MAX_SIZE];

  jls_pkg::state_e st_q, st_d;
  logic [6:0]  size_q, n;
  logic [30:0] tol_q;
  logic [AW-1:0] i_q, j_q;
  logic        rdv_q;
  logic [AW-1:0] rdj_q;
  logic signed [31:0] a_rd_q, x_rd_q, b_rd_q, y_rd_q, xo_rd_q;
  logic signed [63:0] prod_q;
  logic        pv_q;
  logic signed [55:0] acc_q;
  logic signed [31:0] diag_q;
  logic [32:0] maxc_q;
  logic [6:0]  iter_q;
  logic        fault_q, conv_q;
  logic        div_done;
  logic signed [31:0] quot;
  jls_pkg::div_req_t dreq;
  logic signed [47:0] num_c;
  logic signed [55:0] num_w;
  logic [AW-1:0] nlast;
  logic        ld_a_ok, ld_b_ok;
  logic [AW-1:0] rd_addr_j, rd_addr_i;
  logic signed [32:0] dchg;
  logic [32:0] dabs;
  logic [32:0] maxc_n;
  logic        conv_n;

  always_comb begin
    if (size_q == 7'd0) n = 7'd1;
    else if ({25'd0, size_q} > LIM) n = 7'(LIM);
    else n = size_q;
  end
  assign nlast = AW'(n - 7'd1);

  assign busy = (st_q != jls_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 7'd64;
      tol_q  <= 31'd1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == jls_pkg::REG_SIZE) size_q <= cfg_data_i[6:0];
      else tol_q <= cfg_data_i;
    end
  end

  assign ld_a_ok = ({26'd0, row_i} < MAX_SIZE) && ({26'd0, col_i} < MAX_SIZE);
  assign ld_b_ok = {26'd0, row_i} < MAX_SIZE;

  always_ff @(posedge clk_i) begin
    if (start && !busy && operation_i == jls_pkg::OP_LOAD_A && ld_a_ok)
      mem_a[{row_i[AW-1:0], col_i[AW-1:0]}] <= value_i;
    if (start && !busy && operation_i == jls_pkg::OP_LOAD_B && ld_b_ok)
      mem_b[row_i[AW-1:0]] <= value_i;
  end

  // matrix read: (j, i) during MAC, (i, i) in DIAG
  assign rd_addr_j = (st_q == jls_pkg::ST_DIAG) ? i_q : j_q;
  always_ff @(posedge clk_i) begin
    a_rd_q  <= mem_a[{rd_addr_j, i_q}];
    x_rd_q  <= mem_x[j_q];
    b_rd_q  <= mem_b[i_q];
    y_rd_q  <= mem_y[rd_addr_i];
    xo_rd_q <= mem_x[rd_addr_i];
  end
  assign rd_addr_i = i_q;

  assign num_w = {{24{b_rd_q[31]}}, b_rd_q} - acc_q;
  always_comb begin
    if (num_w > 56'sh4000_0000_0000) num_c = 48'sh4000_0000_0000;
    else if (num_w < -56'sh4000_0000_0000) num_c = -48'sh4000_0000_0000;
    else num_c = num_w[47:0];
  end
  assign dchg = {xo_rd_q[31], xo_rd_q} - {y_rd_q[31], y_rd_q};
  assign dabs = dchg[32] ? 33'(-dchg) : dchg;
  assign maxc_n = (dabs > maxc_q) ? dabs : maxc_q;
  assign conv_n = {7'd0, maxc_n} <= ({9'd0, tol_q} * {33'd0, n});

  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = num_c;
    dreq.den   = diag_q;
    st_d = st_q;
    case (st_q)
      jls_pkg::ST_IDLE:
        if (start && operation_i == jls_pkg::OP_SOLVE) st_d = jls_pkg::ST_INIT;
      jls_pkg::ST_INIT:  if (i_q == nlast) st_d = jls_pkg::ST_MAC;
      jls_pkg::ST_MAC:   if (j_q == nlast) st_d = jls_pkg::ST_DIAG;
      jls_pkg::ST_DIAG:  if (!rdv_q && !pv_q) begin
        st_d = jls_pkg::ST_DIV;
        dreq.den = a_rd_q;
        if (a_rd_q != 32'sd0) dreq.start = 1'b1;
      end
      jls_pkg::ST_DIV:
        if (diag_q == 32'sd0 || div_done) begin
          if (i_q == nlast) st_d = jls_pkg::ST_CHECK;
          else st_d = jls_pkg::ST_MAC;
        end
      jls_pkg::ST_CHECK: if (rdv_q && rdj_q == nlast) begin
        if (conv_n || {1'b0, iter_q} >= {1'b0, n}) st_d = jls_pkg::ST_EMIT;
        else st_d = jls_pkg::ST_COPY;
      end
      jls_pkg::ST_COPY:  if (rdv_q && rdj_q == nlast) st_d = jls_pkg::ST_MAC;
      jls_pkg::ST_EMIT:  if (rdv_q && rdj_q == nlast) st_d = jls_pkg::ST_IDLE;
      default: st_d = jls_pkg::ST_IDLE;
    endcase
  end

  jls_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .done_o (div_done),
    .quot_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= jls_pkg::ST_IDLE;
      i_q <= '0; j_q <= '0; rdv_q <= 1'b0; rdj_q <= '0; pv_q <= 1'b0;
      iter_q <= '0; fault_q <= 1'b0; conv_q <= 1'b0; maxc_q <= '0;
      result_valid_o <= 1'b0;
    end else begin
      st_q <= st_d;
      rdv_q <= 1'b0;
      pv_q <= 1'b0;
      result_valid_o <= 1'b0;
      case (st_q)
        jls_pkg::ST_IDLE: if (st_d == jls_pkg::ST_INIT) begin
          i_q <= '0; iter_q <= '0; fault_q <= 1'b0;
        end
        jls_pkg::ST_INIT: begin
          i_q <= (i_q == nlast) ? '0 : i_q + 1'b1;
          j_q <= '0;
          if (i_q == nlast) iter_q <= 7'd1;
        end
        jls_pkg::ST_MAC: begin
          rdv_q <= (j_q != i_q);
          pv_q  <= rdv_q;
          j_q   <= (j_q == nlast) ? '0 : j_q + 1'b1;
        end
        jls_pkg::ST_DIAG: pv_q <= rdv_q;
        jls_pkg::ST_DIV: if (st_d != jls_pkg::ST_DIV) begin
          if (diag_q == 32'sd0) fault_q <= 1'b1;
          i_q <= (i_q == nlast) ? '0 : i_q + 1'b1;
          j_q <= '0;
          maxc_q <= '0;
        end
        jls_pkg::ST_CHECK, jls_pkg::ST_COPY, jls_pkg::ST_EMIT: begin
          rdv_q <= !(rdv_q && rdj_q == nlast);
          rdj_q <= i_q;
          i_q   <= (i_q == nlast) ? '0 : i_q + 1'b1;
          if (st_q == jls_pkg::ST_CHECK && rdv_q) begin
            maxc_q <= maxc_n;
            if (rdj_q == nlast)
              conv_q <= conv_n;
          end
          if (st_q == jls_pkg::ST_EMIT && rdv_q) result_valid_o <= 1'b1;
          if (st_q == jls_pkg::ST_COPY && rdv_q && rdj_q == nlast)
            iter_q <= iter_q + 7'd1;
          if (rdv_q && rdj_q == nlast) begin
            i_q <= '0; rdv_q <= 1'b0; j_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // product, accumulator, diagonal latch, memory writes and the registered result port
  always_ff @(posedge clk_i) begin
    if (rdv_q) prod_q <= a_rd_q * x_rd_q;
    if (st_q == jls_pkg::ST_INIT || (st_q == jls_pkg::ST_DIV && st_d != jls_pkg::ST_DIV))
      acc_q <= '0;
    else if (pv_q) acc_q <= acc_q + 56'(prod_q >>> 16);
    if (st_q == jls_pkg::ST_DIAG && !rdv_q && !pv_q) diag_q <= a_rd_q;
    if (st_q == jls_pkg::ST_INIT) mem_x[i_q] <= jls_pkg::Q_ONE;
    if (st_q == jls_pkg::ST_DIV && st_d != jls_pkg::ST_DIV)
      mem_y[i_q] <= (diag_q == 32'sd0) ?
        (num_c[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : quot;
    if (st_q == jls_pkg::ST_COPY && rdv_q) mem_x[rdj_q] <= y_rd_q;
    index_o <= 6'(rdj_q);
    solution_o <= y_rd_q;
    iteration_count_o <= iter_q;
    converged_o <= conv_q;
    divide_fault_o <= fault_q;
    last_o <= (rdj_q == nlast);
  end
endmodule
